### hdl/gbz_pkg.sv
// Shared types and constants for the 3x3 Gaussian blur with zero padding.
package gbz_pkg;

    // Width of the image size configuration registers.
    localparam int CFG_W = 11;

    // Size the block assumes after reset.
    localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    // Kind of an input transaction, carried on tuser.
    typedef enum logic [0:0] {
        ACTION_PIXEL = 1'b0,
        ACTION_FLUSH = 1'b1
    } action_t;

    // One RGB pixel, red in the lowest byte.
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    // One line store entry: the pixel two rows up and the pixel one row up.
    typedef struct packed {
        pixel_t upper;
        pixel_t middle;
    } line_word_t;

    // Which window border lies outside the image for the current output.
    typedef struct packed {
        logic col_first;
        logic col_last;
        logic row_first;
        logic row_last;
    } edge_mask_t;

endpackage

### hdl/gbz_line_mem.sv
// Line store memory: one write port and one read port with registered read data.
module gbz_line_mem #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  gbz_pkg::line_word_t  wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_W-1:0]    rd_addr,
    output gbz_pkg::line_word_t  rd_data
);

    gbz_pkg::line_word_t mem_reg [DEPTH];
    gbz_pkg::line_word_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Read-first: a read at the address being written returns the old word.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/gbz_kernel.sv
// Masks the 3x3 window at the image borders and applies the 1 2 1 blur kernel.
module gbz_kernel (
    input  gbz_pkg::pixel_t [2:0][2:0] win,   // [column old..new][row top..bottom]
    input  gbz_pkg::edge_mask_t        mask,
    output gbz_pkg::pixel_t            result
);

    gbz_pkg::pixel_t [2:0][2:0] taps;
    logic [2:0][2:0][7:0]       red_taps;
    logic [2:0][2:0][7:0]       green_taps;
    logic [2:0][2:0][7:0]       blue_taps;

    // Weighted sum of nine taps; the largest sum, 16 * 255, fits in 12 bits.
    function automatic logic [7:0] blur(input logic [2:0][2:0][7:0] t);
        logic [11:0] corners;
        logic [11:0] sides;
        logic [11:0] total;
        corners = 12'(t[0][0]) + 12'(t[2][0]) + 12'(t[0][2]) + 12'(t[2][2]);
        sides   = 12'(t[1][0]) + 12'(t[0][1]) + 12'(t[2][1]) + 12'(t[1][2]);
        total   = corners + (sides << 1) + (12'(t[1][1]) << 2);
        return total[11:4];
    endfunction

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if ((k == 0 && mask.col_first) || (k == 2 && mask.col_last) ||
                    (j == 0 && mask.row_first) || (j == 2 && mask.row_last))
                begin
                    taps[k][j] = '0;
                end
                else
                begin
                    taps[k][j] = win[k][j];
                end
                red_taps[k][j]   = taps[k][j].red;
                green_taps[k][j] = taps[k][j].green;
                blue_taps[k][j]  = taps[k][j].blue;
            end
        end
    end

    assign result.red   = blur(red_taps);
    assign result.green = blur(green_taps);
    assign result.blue  = blur(blue_taps);

endmodule

### hdl/gaussian_blur_3x3_zero_pad.sv
// Top level of the 3x3 Gaussian blur with zero padding over an RGB pixel stream.
//
// Usage: pixels enter in raster order on the slave stream, one transaction per
// pixel, with s_tuser low and red, green, blue in s_tdata. After the W*H pixels
// of a frame the source sends W+1 flush transactions (s_tuser high); every
// transaction from the second column of the second row on releases the blurred
// pixel one row and one column behind it, and the last flush releases the final
// pixel with m_tlast set.
// The frame size is written on the cfg port (index 0 width, index 1 height) while
// the block is idle; out of range values are clamped to 1 .. MAX_WIDTH/HEIGHT.
//
// Throughput is one transaction per clock while the receiver does not stall. A result
// reaches the master stream through the line store read and the window shift,
// then the blur sum is registered in the output register.
// A same-column read that overlaps the write of the previous transaction is
// served from a forwarding register, so narrow images also run at full rate.
//
// Reset returns the scan position to the start of a frame and sets the size to
// 640 by 480. The line stores are not cleared; entries not yet written are
// always masked by the border logic. When the receiver stalls, the output
// register and the window stage hold their results and the input keeps taking
// transactions until the read stage is full as well; then s_tready drops.
module gaussian_blur_3x3_zero_pad #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Input stream.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [23:0]                   s_tdata,   // red_in, green_in, blue_in
    input  logic                          s_tuser,   // action
    // Output stream.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [23:0]                   m_tdata,   // red_out, green_out, blue_out
    output logic                          m_tlast,   // frame_last
    // Configuration write port.
    input  logic                          cfg_we,
    input  logic [0:0]                    cfg_index,
    input  logic [gbz_pkg::CFG_W-1:0]     cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WID_W = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W = $clog2(MAX_HEIGHT + 4);

    typedef struct packed {
        logic [COL_W-1:0]    col;
        gbz_pkg::pixel_t     pix;
        logic                emit;
        logic                last;
        gbz_pkg::edge_mask_t mask;
    } read_stage_t;

    // Configuration registers.
    logic [gbz_pkg::CFG_W-1:0] width_reg;
    logic [gbz_pkg::CFG_W-1:0] height_reg;
    logic [WID_W-1:0]          w_eff;
    logic [ROW_W-1:0]          h_eff;

    // Scan position of the next input transaction.
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_next;

    // Position decode for the incoming transaction.
    logic                wrap;
    logic [COL_W-1:0]    cur_col;
    logic [ROW_W-1:0]    cur_row;
    logic [WID_W-1:0]    cur_col_p1;
    logic                row_end;
    logic                has_out;
    logic [COL_W-1:0]    out_col;
    logic [ROW_W-1:0]    out_row;
    logic                past_end;
    logic                restart;
    read_stage_t         s1_next;

    // Pipeline.
    logic                       accept;
    logic                       out_free;
    logic                       s2_ready;
    logic                       s1_adv;
    logic                       s1_valid_reg;
    read_stage_t                s1_reg;
    logic                       fwd_reg;
    gbz_pkg::line_word_t        fwd_word_reg;
    gbz_pkg::line_word_t        rd_word;
    gbz_pkg::line_word_t        hist_word;
    gbz_pkg::line_word_t        wr_word;
    gbz_pkg::pixel_t [2:0][2:0] win_reg;
    logic                       s2_valid_reg;
    logic                       s2_last_reg;
    gbz_pkg::edge_mask_t        s2_mask_reg;
    gbz_pkg::pixel_t            blur_pix;
    logic                       out_valid_reg;
    gbz_pkg::pixel_t            out_pix_reg;
    logic                       out_last_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= gbz_pkg::WIDTH_RESET;
            height_reg <= gbz_pkg::HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (gbz_pkg::cfg_reg_t'(cfg_index))
                gbz_pkg::CFG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                gbz_pkg::CFG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default:                   width_reg  <= width_reg;
            endcase
        end
    end

    // Clamp the frame size to the range the line stores support.
    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = WID_W'(1);
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            w_eff = WID_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WID_W'(width_reg);
        end

        if (height_reg == '0)
        begin
            h_eff = ROW_W'(1);
        end
        else if (32'(height_reg) > MAX_HEIGHT)
        begin
            h_eff = ROW_W'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = ROW_W'(height_reg);
        end
    end

    // Handshake chain: each stage moves when the one after it can take its item.
    assign out_free = !out_valid_reg || m_tready;
    assign s2_ready = !s2_valid_reg || out_free;
    assign s1_adv   = s1_valid_reg && s2_ready;
    assign s_tready = !s1_valid_reg || s2_ready;
    assign accept   = s_tvalid && s_tready;

    // Decode where the incoming transaction sits and which output it releases.
    always_comb
    begin
        wrap    = WID_W'(col_reg) >= w_eff;
        cur_col = wrap ? '0 : col_reg;
        cur_row = wrap ? row_reg + ROW_W'(1) : row_reg;

        s1_next.col = cur_col;
        if (gbz_pkg::action_t'(s_tuser) == gbz_pkg::ACTION_PIXEL && cur_row < h_eff)
        begin
            s1_next.pix = gbz_pkg::pixel_t'(s_tdata);
        end
        else
        begin
            s1_next.pix = '0;
        end

        // The released output is one column to the left, wrapping to the end
        // of the row two rows up at the first column.
        if (cur_col != '0)
        begin
            out_col = cur_col - COL_W'(1);
            has_out = cur_row >= ROW_W'(1);
            out_row = cur_row - ROW_W'(1);
        end
        else
        begin
            out_col = COL_W'(w_eff - WID_W'(1));
            has_out = cur_row >= ROW_W'(2);
            out_row = cur_row - ROW_W'(2);
        end

        past_end     = has_out && out_row >= h_eff;
        s1_next.emit = has_out && !past_end;
        s1_next.mask.col_first = out_col == '0;
        s1_next.mask.col_last  = WID_W'(out_col) == w_eff - WID_W'(1);
        s1_next.mask.row_first = out_row == '0;
        s1_next.mask.row_last  = out_row == h_eff - ROW_W'(1);
        s1_next.last = s1_next.emit && s1_next.mask.col_last && s1_next.mask.row_last;
        restart      = past_end || s1_next.last;

        cur_col_p1 = WID_W'(cur_col) + WID_W'(1);
        row_end    = cur_col_p1 >= w_eff;
        if (restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (row_end)
        begin
            col_next = '0;
            row_next = cur_row + ROW_W'(1);
        end
        else
        begin
            col_next = COL_W'(cur_col_p1);
            row_next = cur_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Read stage: the line store word for this column arrives in the next cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    // The previous transaction writes the same column in the cycle this one
    // reads it when the two share a column; keep its word for forwarding.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg       <= s1_next;
            fwd_reg      <= s1_adv && (s1_reg.col == cur_col);
            fwd_word_reg <= wr_word;
        end
    end

    assign hist_word      = fwd_reg ? fwd_word_reg : rd_word;
    assign wr_word.upper  = hist_word.middle;
    assign wr_word.middle = s1_reg.pix;

    gbz_line_mem #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (COL_W)
    ) u_line_mem (
        .clk     (clk),
        .wr_en   (s1_adv),
        .wr_addr (s1_reg.col),
        .wr_data (wr_word),
        .rd_en   (accept),
        .rd_addr (cur_col),
        .rd_data (rd_word)
    );

    // Window stage: shift in the new column of top, middle and bottom pixels.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (s1_adv)
        begin
            win_reg[0]    <= win_reg[1];
            win_reg[1]    <= win_reg[2];
            win_reg[2][0] <= hist_word.upper;
            win_reg[2][1] <= hist_word.middle;
            win_reg[2][2] <= s1_reg.pix;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg && s1_reg.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_last_reg <= s1_reg.last;
            s2_mask_reg <= s1_reg.mask;
        end
    end

    gbz_kernel u_kernel (
        .win    (win_reg),
        .mask   (s2_mask_reg),
        .result (blur_pix)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && out_free)
        begin
            out_pix_reg  <= blur_pix;
            out_last_reg <= s2_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_pix_reg;
    assign m_tlast  = out_last_reg;

    // A stalled read stage keeps its transaction until the window stage frees.
    a_read_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s2_ready |=> s1_valid_reg && $stable(s1_reg))
        else $error("read stage lost or changed a stalled transaction");

    // A frame end or an overrun sends the scan back to the first pixel.
    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && restart |=> col_reg == '0 && row_reg == '0)
        else $error("scan position not cleared at frame end");

    // A finished window result reaches the output register in the next cycle.
    a_result_moves: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && out_free |=> m_tvalid)
        else $error("window result not moved to the output");

    // The row counter never runs more than two rows past the tallest frame.
    a_row_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= ROW_W'(MAX_HEIGHT + 2))
        else $error("row counter out of range");

endmodule

### tb/tb_gaussian_blur_3x3_zero_pad.sv
// Testbench for the 3x3 Gaussian blur with zero padding: random frames checked against a predictor.
`timescale 1ns / 1ps

module tb_gaussian_blur_3x3_zero_pad;

    // These match the default parameters of the block.
    localparam int unsigned MAX_W = 1024;
    localparam int unsigned MAX_H = 1024;

    localparam int CFG_W = gbz_pkg::CFG_W;

    // The watchdog gives up after this many cycles in a row without any transaction.
    // The longest planned hold-off comes from test_backpressure, and random stalls are far shorter.
    localparam int unsigned STUCK_LIMIT = 4000;

    // The pause at the end of a phase lets the block's pipeline registers settle after the
    // last expected result, with some margin.
    localparam int unsigned SETTLE_CYCLES = 8;

    // One blurred pixel together with the end-of-frame flag.
    typedef struct packed {
        gbz_pkg::pixel_t pix;
        logic            last;
    } blurred_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [23:0]        s_tdata = '0;   // red_in, green_in, blue_in
    logic               s_tuser = gbz_pkg::ACTION_PIXEL;   // action
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [23:0]        m_tdata;        // red_out, green_out, blue_out
    logic               m_tlast;        // frame_last
    logic               cfg_we = 1'b0;
    logic [0:0]         cfg_index = gbz_pkg::CFG_IMAGE_WIDTH;
    logic [CFG_W-1:0]   cfg_data = '0;

    gaussian_blur_3x3_zero_pad dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // Predictor state: a copy of the line stores, the 3x3 window, the scan position
    // and the size registers. The line stores start cleared here; entries the block
    // never wrote in the current frame always fall under the border mask anyway.
    gbz_pkg::pixel_t    older_line [MAX_W];
    gbz_pkg::pixel_t    newer_line [MAX_W];
    gbz_pkg::pixel_t    win [3][3];     // [column old..new][top, middle, bottom]
    int unsigned        scan_col;
    int unsigned        scan_row;
    logic [CFG_W-1:0]   width_reg;
    logic [CFG_W-1:0]   height_reg;

    blurred_t           blurred_q[$];
    int unsigned        mismatch_count = 0;
    int unsigned        items_sent = 0;

    // Random flow control. gap_pct is the chance that the source idles for a cycle,
    // stall_pct the chance that the sink drops tready. hold_off_len forces tready low
    // for that many cycles; the sink process counts it down on its own.
    int unsigned        gap_pct = 0;
    int unsigned        stall_pct = 0;
    int unsigned        hold_off_len = 0;

    function automatic int unsigned clamp_dim(logic [CFG_W-1:0] v, int unsigned hi);
        if (v < 1)
            return 1;
        if (v > hi)
            return hi;
        return 32'(v);
    endfunction

    // Line stores and window are cleared; size registers and scan position go back to the values after reset.
    task automatic reset_predictor();
        for (int i = 0; i < MAX_W; i++)
        begin
            older_line[i] = '0;
            newer_line[i] = '0;
        end
        for (int k = 0; k < 3; k++)
            for (int j = 0; j < 3; j++)
                win[k][j] = '0;
        scan_col = 0;
        scan_row = 0;
        width_reg = gbz_pkg::WIDTH_RESET;
        height_reg = gbz_pkg::HEIGHT_RESET;
    endtask

    // Advances the predictor by one accepted input transaction and queues the blurred
    // pixel that this transaction releases, if any. The output for raster pixel q is
    // released by input transaction q + W + 1, so it lags one row and one column.
    task automatic predict_blur(gbz_pkg::action_t act, gbz_pkg::pixel_t pin);
        int unsigned     w;
        int unsigned     h;
        int unsigned     c;
        int unsigned     r;
        int unsigned     cc;
        int unsigned     cr;
        int unsigned     wt;
        int unsigned     acc [3];
        gbz_pkg::pixel_t v;
        gbz_pkg::pixel_t up;
        gbz_pkg::pixel_t mid;
        gbz_pkg::pixel_t nb;
        bit              ok;
        bit              off;
        blurred_t        res;

        w = clamp_dim(width_reg, MAX_W);
        h = clamp_dim(height_reg, MAX_H);
        c = scan_col;
        r = scan_row;
        if (c >= w)
        begin
            c = 0;
            r++;
        end

        // A flush inside the frame counts as a black pixel, and anything past the
        // last row is padding whose data is dropped.
        v = '0;
        if (act == gbz_pkg::ACTION_PIXEL && r < h)
            v = pin;

        up = older_line[c];
        mid = newer_line[c];
        older_line[c] = mid;
        newer_line[c] = v;
        for (int j = 0; j < 3; j++)
        begin
            win[0][j] = win[1][j];
            win[1][j] = win[2][j];
        end
        win[2][0] = up;
        win[2][1] = mid;
        win[2][2] = v;

        // The window center sits one column back; at column 0 it is the last column
        // of the row before, which is one row further up.
        if (c >= 1)
        begin
            cc = c - 1;
            ok = (r >= 1);
            cr = ok ? r - 1 : 0;
        end
        else
        begin
            cc = w - 1;
            ok = (r >= 2);
            cr = ok ? r - 2 : 0;
        end

        if (c + 1 >= w)
        begin
            scan_col = 0;
            scan_row = r + 1;
        end
        else
        begin
            scan_col = c + 1;
            scan_row = r;
        end

        if (!ok)
            return;
        if (cr >= h)
        begin
            scan_col = 0;
            scan_row = 0;
            return;
        end

        acc[0] = 0;
        acc[1] = 0;
        acc[2] = 0;
        for (int k = 0; k < 3; k++)
            for (int j = 0; j < 3; j++)
            begin
                off = (k == 0 && cc == 0) || (k == 2 && cc == w - 1)
                   || (j == 0 && cr == 0) || (j == 2 && cr == h - 1);
                nb = off ? gbz_pkg::pixel_t'('0) : win[k][j];
                // Kernel 1 2 1 / 2 4 2 / 1 2 1 is the outer product of 1 2 1.
                wt = ((k == 1) ? 2 : 1) * ((j == 1) ? 2 : 1);
                acc[0] += wt * nb.red;
                acc[1] += wt * nb.green;
                acc[2] += wt * nb.blue;
            end

        res.pix.red = 8'(acc[0] >> 4);
        res.pix.green = 8'(acc[1] >> 4);
        res.pix.blue = 8'(acc[2] >> 4);
        res.last = (cr == h - 1) && (cc == w - 1);
        blurred_q.push_back(res);
        if (res.last)
        begin
            scan_col = 0;
            scan_row = 0;
        end
    endtask

    // Offers one transaction, with random idle cycles ahead of it, and waits until the
    // block takes it. tvalid stays high on return so back-to-back items keep it up;
    // end_burst lowers it.
    task automatic send_item(gbz_pkg::action_t act, gbz_pkg::pixel_t pin);
        @(negedge clk);
        while ($urandom_range(99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= pin;
        do
            @(posedge clk);
        while (!s_tready);
        predict_blur(act, pin);
        items_sent++;
    endtask

    task automatic end_burst();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    // Waits for every queued result, then lets the pipeline settle before a register
    // write.
    task automatic wait_drained();
        while (blurred_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes width and then height on consecutive cycles; only called while idle.
    task automatic set_frame_size(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= gbz_pkg::CFG_IMAGE_WIDTH;
        cfg_data <= w;
        @(negedge clk);
        cfg_index <= gbz_pkg::CFG_IMAGE_HEIGHT;
        cfg_data <= h;
        @(negedge clk);
        cfg_we <= 1'b0;
        width_reg = w;
        height_reg = h;
    endtask

    function automatic gbz_pkg::pixel_t random_pixel(bit saturated);
        gbz_pkg::pixel_t p;
        if (saturated)
        begin
            p.red = $urandom_range(1) ? 8'hFF : 8'h00;
            p.green = $urandom_range(1) ? 8'hFF : 8'h00;
            p.blue = $urandom_range(1) ? 8'hFF : 8'h00;
        end
        else
            p = gbz_pkg::pixel_t'(24'($urandom));
        return p;
    endfunction

    // Sends one complete frame: W*H pixel transactions followed by the W+1 flushes
    // that drain the last row. Some pixels are replaced by flushes (black pixels) and
    // some flushes by pixels (ignored padding). The size must already be written.
    task automatic run_frame(int unsigned flush_pct, int unsigned pad_pct);
        int unsigned w;
        int unsigned h;
        bit          saturated;

        w = clamp_dim(width_reg, MAX_W);
        h = clamp_dim(height_reg, MAX_H);
        saturated = ($urandom_range(4) == 0);
        for (int unsigned i = 0; i < w * h; i++)
        begin
            if ($urandom_range(99) < flush_pct)
                send_item(gbz_pkg::ACTION_FLUSH, random_pixel(saturated));
            else
                send_item(gbz_pkg::ACTION_PIXEL, random_pixel(saturated));
        end
        for (int unsigned i = 0; i <= w; i++)
        begin
            if ($urandom_range(99) < pad_pct)
                send_item(gbz_pkg::ACTION_PIXEL, random_pixel(saturated));
            else
                send_item(gbz_pkg::ACTION_FLUSH, random_pixel(saturated));
        end
        end_burst();
    endtask

    // Hand-picked pixels on a 3x3 frame: the channel extremes, alternating bit
    // patterns, a flush inside the frame and a pixel sent where a flush belongs.
    // Then a 1x1 frame, which also checks that a size of zero is clamped to one.
    task automatic test_directed();
        gap_pct = 0;
        stall_pct = 0;
        set_frame_size(11'd3, 11'd3);
        send_item(gbz_pkg::ACTION_PIXEL, 24'h000000);
        send_item(gbz_pkg::ACTION_PIXEL, 24'hFFFFFF);
        send_item(gbz_pkg::ACTION_PIXEL, 24'h55AA55);
        send_item(gbz_pkg::ACTION_PIXEL, 24'hAA55AA);
        send_item(gbz_pkg::ACTION_FLUSH, 24'hFFFFFF);
        send_item(gbz_pkg::ACTION_PIXEL, 24'h0000FF);
        send_item(gbz_pkg::ACTION_PIXEL, 24'h00FF00);
        send_item(gbz_pkg::ACTION_PIXEL, 24'hFF0000);
        send_item(gbz_pkg::ACTION_PIXEL, 24'h808080);
        send_item(gbz_pkg::ACTION_FLUSH, 24'h000000);
        send_item(gbz_pkg::ACTION_PIXEL, 24'h123456);
        send_item(gbz_pkg::ACTION_FLUSH, 24'hFFFFFF);
        send_item(gbz_pkg::ACTION_FLUSH, 24'h000000);
        end_burst();
        wait_drained();

        set_frame_size(11'd0, 11'd0);
        send_item(gbz_pkg::ACTION_PIXEL, 24'hFFFFFF);
        send_item(gbz_pkg::ACTION_FLUSH, 24'h000000);
        send_item(gbz_pkg::ACTION_FLUSH, 24'h000000);
        end_burst();
        wait_drained();
    endtask

    // Random small frames under each flow control mode in turn; the first mode has no
    // idling at all so the block also runs at full rate.
    task automatic test_random_frames();
        int unsigned phase_end;
        for (int mode = 0; mode < 4; mode++)
        begin
            gap_pct = (mode == 1 || mode == 3) ? ((mode == 1) ? 53 : 14) : 0;
            stall_pct = (mode == 2 || mode == 3) ? ((mode == 2) ? 53 : 14) : 0;
            phase_end = items_sent + 80;
            while (items_sent < phase_end)
            begin
                if ($urandom_range(9) == 0)
                    set_frame_size(CFG_W'($urandom_range(13, 40)),
                                   CFG_W'($urandom_range(1, 10)));
                else
                    set_frame_size(CFG_W'($urandom_range(1, 12)),
                                   CFG_W'($urandom_range(1, 10)));
                run_frame(5, 25);
                wait_drained();
            end
        end
    endtask

    // The sink holds off for a long stretch while the source keeps offering, so the
    // block fills up and has to drop s_tready.
    task automatic test_backpressure();
        gap_pct = 0;
        stall_pct = 0;
        set_frame_size(11'd6, 11'd5);
        hold_off_len = 300;
        run_frame(0, 0);
        wait_drained();
    endtask

    // Largest size: a height above the maximum is clamped to a one-column frame of
    // full height.
    task automatic test_extreme_sizes();
        gap_pct = 14;
        stall_pct = 14;
        set_frame_size(11'd1, 11'h7FF);
        run_frame(2, 10);
        wait_drained();
    endtask

    // Sink side: tready changes on the falling edge.
    always @(negedge clk)
    begin
        if (hold_off_len > 0)
        begin
            hold_off_len = hold_off_len - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Every result transaction is compared with the oldest expectation.
    always @(posedge clk)
    begin
        blurred_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (blurred_q.size() == 0)
            begin
                mismatch_count++;
                $display("%0t ns: unexpected result: expected none, actual %h last %0b",
                         $time, m_tdata, m_tlast);
            end
            else
            begin
                want = blurred_q.pop_front();
                if (m_tdata[7:0] !== want.pix.red || m_tdata[15:8] !== want.pix.green
                    || m_tdata[23:16] !== want.pix.blue || m_tlast !== want.last)
                begin
                    mismatch_count++;
                    $display("%0t ns: mismatch: expected %h last %0b, actual %h last %0b",
                             $time, want.pix, want.last, m_tdata, m_tlast);
                end
            end
        end
    end

    // Watchdog: any transaction on either side restarts the count.
    always @(posedge clk)
    begin
        int unsigned quiet_cycles;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= STUCK_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        reset_predictor();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_frames();
        test_backpressure();
        test_extreme_sizes();

        if (mismatch_count == 0 && blurred_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### sim.f
hdl/gbz_pkg.sv
hdl/gbz_line_mem.sv
hdl/gbz_kernel.sv
hdl/gaussian_blur_3x3_zero_pad.sv
tb/tb_gaussian_blur_3x3_zero_pad.sv
